### hdl/gprpt_pkg.sv
// shared constants, types and sine table of the gyro packet receiver
package gprpt_pkg;

	localparam int unsigned UPDATE_BYTES = 6;
	localparam logic [7:0]  UPDATE_LEN   = 8'h06;
	localparam logic [7:0]  REPLY_LEN    = 8'h01;
	localparam logic [15:0] ANGLE_LIMIT  = 16'd3600;
	localparam logic [13:0] TRIG_ONE     = 14'd10000;

	// floor(v / 10) as (v * RECIP10) >> 16, exact for v below 2048
	localparam logic [12:0] RECIP10      = 13'd6554;
	// floor(v / 10000) as (v * RECIP10K) >> 45, exact for v below 2**31
	localparam logic [31:0] RECIP10K     = 32'd3518437209;
	localparam int unsigned RECIP10K_SH  = 45;

	localparam logic [2:0] CFG_WAKEUP   = 3'd0;
	localparam logic [2:0] CFG_UPDATE   = 3'd1;
	localparam logic [2:0] CFG_REPLY    = 3'd2;
	localparam logic [2:0] CFG_SHIFT_X  = 3'd3;
	localparam logic [2:0] CFG_SHIFT_Y  = 3'd4;
	localparam logic [2:0] CFG_INVERT_X = 3'd5;
	localparam logic [2:0] CFG_INVERT_Y = 3'd6;

	typedef enum logic [1:0] {
		KIND_UPDATE = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_REPLY  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] wakeup;
		logic [7:0] update;
		logic [7:0] reply;
	} codes_t;

	typedef struct packed {
		logic        valid;
		logic        reply;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] angle;
		logic [7:0]  idx;
	} pkt_t;

	// sine of whole degrees 0..90, scaled by 10000
	localparam logic [13:0] SIN_DEG [0:90] = '{
		14'd0,    14'd175,  14'd349,  14'd523,  14'd698,
		14'd872,  14'd1045, 14'd1219, 14'd1392, 14'd1564,
		14'd1736, 14'd1908, 14'd2079, 14'd2250, 14'd2419,
		14'd2588, 14'd2756, 14'd2924, 14'd3090, 14'd3256,
		14'd3420, 14'd3584, 14'd3746, 14'd3907, 14'd4067,
		14'd4226, 14'd4384, 14'd4540, 14'd4695, 14'd4848,
		14'd5000, 14'd5150, 14'd5299, 14'd5446, 14'd5592,
		14'd5736, 14'd5878, 14'd6018, 14'd6157, 14'd6293,
		14'd6428, 14'd6561, 14'd6691, 14'd6820, 14'd6947,
		14'd7071, 14'd7193, 14'd7314, 14'd7431, 14'd7547,
		14'd7660, 14'd7771, 14'd7880, 14'd7986, 14'd8090,
		14'd8192, 14'd8290, 14'd8387, 14'd8480, 14'd8572,
		14'd8660, 14'd8746, 14'd8829, 14'd8910, 14'd8988,
		14'd9063, 14'd9135, 14'd9205, 14'd9272, 14'd9336,
		14'd9397, 14'd9455, 14'd9511, 14'd9563, 14'd9613,
		14'd9659, 14'd9703, 14'd9744, 14'd9781, 14'd9816,
		14'd9848, 14'd9877, 14'd9903, 14'd9925, 14'd9945,
		14'd9962, 14'd9976, 14'd9986, 14'd9994, 14'd9998,
		14'd10000
	};

	function automatic logic [13:0] sin_deg(input logic [6:0] k);
		logic [13:0] v;
		if (k > 7'd90) begin
			v = TRIG_ONE;
		end else begin
			v = SIN_DEG[k];
		end
		return v;
	endfunction

endpackage

### hdl/gyro_packet_receiver_pose_transform_top.sv
// top level: gyro packet deframer with signed pose transform pipeline
// Accepts one received byte per cycle on the rx channel and emits one result per complete
// packet on the pose channel. Wakeup and command bytes are checked against the configured
// codes and the length byte against the expected length; any mismatch restarts the hunt.
// A result passes one parser register, four sine/cosine stages, a product stage, a sum
// stage, a divide-by-10000 reciprocal multiply stage and the output register.
// All stages advance together and hold while a result waits on pose_ready, during which
// rx_ready is low. Configuration writes take effect at once and belong to idle periods.
module gyro_packet_receiver_pose_transform_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  logic [7:0]         rx_byte,
	output logic               pose_valid,
	input  logic               pose_ready,
	output logic [1:0]         packet_kind,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [11:0]        heading,
	output logic signed [15:0] raw_x,
	output logic signed [15:0] raw_y,
	output logic [7:0]         reply_index,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef struct packed {
		gprpt_pkg::kind_t   kind;
		logic [15:0]        raw_x;
		logic [15:0]        raw_y;
		logic [11:0]        heading;
		logic [7:0]         idx;
		logic signed [16:0] xe;
		logic signed [16:0] ye;
	} meta_t;

	gprpt_pkg::codes_t  codes_q;
	logic signed [15:0] shift_x_q;
	logic signed [15:0] shift_y_q;
	logic               invert_x_q;
	logic               invert_y_q;

	logic               en;
	gprpt_pkg::pkt_t    pkt_s1;
	logic signed [14:0] sin_s5;
	logic signed [14:0] cos_s5;

	logic  v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	meta_t meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7, meta_s8;
	meta_t meta_in;

	logic signed [31:0] mdx_s6, mdy_s6, sxc_s6, sys_s6, syc_s6, sxs_s6;
	logic signed [31:0] num_x_s7, num_y_s7;
	logic               neg_x_s8, neg_y_s8;
	logic [62:0]        prod_x_s8, prod_y_s8;

	logic signed [17:0] dx, dy;
	logic [30:0]        mag_x, mag_y;
	logic signed [15:0] sat_x, sat_y;

	logic               pose_valid_q;
	gprpt_pkg::kind_t   kind_q;
	logic signed [15:0] pos_x_q, pos_y_q, raw_x_q, raw_y_q;
	logic [11:0]        heading_q;
	logic [7:0]         reply_index_q;

	function automatic logic signed [15:0] quot_sat(input logic neg, input logic [62:0] p);
		logic [17:0]        q;
		logic signed [18:0] v;
		logic signed [15:0] r;
		q = p[62:gprpt_pkg::RECIP10K_SH];
		v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (v > 19'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -19'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q    <= '0;
			shift_x_q  <= '0;
			shift_y_q  <= '0;
			invert_x_q <= 1'b0;
			invert_y_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gprpt_pkg::CFG_WAKEUP:   codes_q.wakeup <= cfg_data[7:0];
				gprpt_pkg::CFG_UPDATE:   codes_q.update <= cfg_data[7:0];
				gprpt_pkg::CFG_REPLY:    codes_q.reply  <= cfg_data[7:0];
				gprpt_pkg::CFG_SHIFT_X:  shift_x_q      <= cfg_data;
				gprpt_pkg::CFG_SHIFT_Y:  shift_y_q      <= cfg_data;
				gprpt_pkg::CFG_INVERT_X: invert_x_q     <= cfg_data[0];
				gprpt_pkg::CFG_INVERT_Y: invert_y_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !(pose_valid_q && !pose_ready);
	assign rx_ready = en;

	gprpt_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.codes    (codes_q),
		.pkt_s1   (pkt_s1)
	);

	gprpt_sincos u_sincos (
		.clk    (clk),
		.en     (en),
		.angle  (pkt_s1.angle[11:0]),
		.sin_s5 (sin_s5),
		.cos_s5 (cos_s5)
	);

	always_comb begin
		if (pkt_s1.reply) begin
			meta_in.kind = gprpt_pkg::KIND_REPLY;
		end else if (pkt_s1.angle >= gprpt_pkg::ANGLE_LIMIT) begin
			meta_in.kind = gprpt_pkg::KIND_REJECT;
		end else begin
			meta_in.kind = gprpt_pkg::KIND_UPDATE;
		end
		meta_in.raw_x   = pkt_s1.x;
		meta_in.raw_y   = pkt_s1.y;
		meta_in.heading = pkt_s1.angle[11:0];
		meta_in.idx     = pkt_s1.idx;
		meta_in.xe      = invert_x_q ? -17'(signed'(pkt_s1.x)) : 17'(signed'(pkt_s1.x));
		meta_in.ye      = invert_y_q ? -17'(signed'(pkt_s1.y)) : 17'(signed'(pkt_s1.y));
	end

	assign dx    = 18'(meta_s5.xe) - 18'(shift_x_q);
	assign dy    = 18'(meta_s5.ye) - 18'(shift_y_q);
	assign mag_x = num_x_s7[31] ? 31'(-num_x_s7) : num_x_s7[30:0];
	assign mag_y = num_y_s7[31] ? 31'(-num_y_s7) : num_y_s7[30:0];
	assign sat_x = quot_sat(neg_x_s8, prod_x_s8);
	assign sat_y = quot_sat(neg_y_s8, prod_y_s8);

	// stage valids and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			v_s6         <= 1'b0;
			v_s7         <= 1'b0;
			v_s8         <= 1'b0;
			pose_valid_q <= 1'b0;
		end else if (en) begin
			v_s2         <= pkt_s1.valid;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			v_s5         <= v_s4;
			v_s6         <= v_s5;
			v_s7         <= v_s6;
			v_s8         <= v_s7;
			pose_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_in;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
			meta_s8 <= meta_s7;

			mdx_s6 <= 32'(dx) * 32'sd10000;
			mdy_s6 <= 32'(dy) * 32'sd10000;
			sxc_s6 <= 32'(shift_x_q) * 32'(cos_s5);
			sys_s6 <= 32'(shift_y_q) * 32'(sin_s5);
			syc_s6 <= 32'(shift_y_q) * 32'(cos_s5);
			sxs_s6 <= 32'(shift_x_q) * 32'(sin_s5);

			num_x_s7 <= mdx_s6 + sxc_s6 - sys_s6;
			num_y_s7 <= mdy_s6 + syc_s6 + sxs_s6;

			neg_x_s8  <= num_x_s7[31];
			neg_y_s8  <= num_y_s7[31];
			prod_x_s8 <= 63'(mag_x) * 63'(gprpt_pkg::RECIP10K);
			prod_y_s8 <= 63'(mag_y) * 63'(gprpt_pkg::RECIP10K);

			kind_q <= meta_s8.kind;
			case (meta_s8.kind)
				gprpt_pkg::KIND_UPDATE: begin
					pos_x_q       <= sat_x;
					pos_y_q       <= sat_y;
					heading_q     <= meta_s8.heading;
					raw_x_q       <= meta_s8.raw_x;
					raw_y_q       <= meta_s8.raw_y;
					reply_index_q <= '0;
				end
				gprpt_pkg::KIND_REJECT: begin
					pos_x_q       <= '0;
					pos_y_q       <= '0;
					heading_q     <= '0;
					raw_x_q       <= meta_s8.raw_x;
					raw_y_q       <= meta_s8.raw_y;
					reply_index_q <= '0;
				end
				gprpt_pkg::KIND_REPLY: begin
					pos_x_q       <= '0;
					pos_y_q       <= '0;
					heading_q     <= '0;
					raw_x_q       <= '0;
					raw_y_q       <= '0;
					reply_index_q <= meta_s8.idx;
				end
				default: begin
					pos_x_q       <= '0;
					pos_y_q       <= '0;
					heading_q     <= '0;
					raw_x_q       <= '0;
					raw_y_q       <= '0;
					reply_index_q <= '0;
				end
			endcase
		end
	end

	assign pose_valid  = pose_valid_q;
	assign packet_kind = kind_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign heading     = heading_q;
	assign raw_x       = raw_x_q;
	assign raw_y       = raw_y_q;
	assign reply_index = reply_index_q;

	// no byte transfer while a result is held back
	a_stall_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && !pose_ready) |-> !rx_ready)
		else $error("byte taken while result stalled");

	a_update_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && packet_kind == gprpt_pkg::KIND_UPDATE)
		|-> (heading < gprpt_pkg::ANGLE_LIMIT[11:0]))
		else $error("update result with out-of-range heading");

	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && packet_kind == gprpt_pkg::KIND_REPLY)
		|-> (pos_x == 16'sd0 && pos_y == 16'sd0 && raw_x == 16'sd0 && heading == 12'd0))
		else $error("reply result carries coordinates");

	a_index_only_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && packet_kind != gprpt_pkg::KIND_REPLY) |-> (reply_index == 8'd0))
		else $error("non-reply result carries a flag index");

	a_reject_no_pose: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && packet_kind == gprpt_pkg::KIND_REJECT)
		|-> (pos_x == 16'sd0 && pos_y == 16'sd0 && heading == 12'd0))
		else $error("rejected update carries a pose");

endmodule

### hdl/gprpt_parser.sv
// byte deframer: hunts for wakeup, checks command and length, gathers payload
module gprpt_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   rx_valid,
	input  logic [7:0]             rx_byte,
	input  gprpt_pkg::codes_t      codes,
	output gprpt_pkg::pkt_t        pkt_s1
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_CMD,
		PH_LEN,
		PH_DATA
	} phase_t;

	localparam logic [2:0] LAST_CNT = 3'(gprpt_pkg::UPDATE_BYTES - 1);

	phase_t     phase_q;
	logic       cmd_reply_q;
	logic [2:0] cnt_q;
	logic [7:0] payload_q [0:gprpt_pkg::UPDATE_BYTES-2];
	logic       last;
	logic [7:0] need_len;

	assign last     = cmd_reply_q || (cnt_q == LAST_CNT);
	assign need_len = cmd_reply_q ? gprpt_pkg::REPLY_LEN : gprpt_pkg::UPDATE_LEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cmd_reply_q <= 1'b0;
			cnt_q       <= '0;
			pkt_s1      <= '0;
		end else if (en) begin
			pkt_s1.valid <= rx_valid && (phase_q == PH_DATA) && last;
			if (rx_valid) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (rx_byte == codes.wakeup) begin
							cnt_q   <= '0;
							phase_q <= PH_CMD;
						end
					end
					PH_CMD: begin
						if (rx_byte == codes.update) begin
							cmd_reply_q <= 1'b0;
							phase_q     <= PH_LEN;
						end else if (rx_byte == codes.reply) begin
							cmd_reply_q <= 1'b1;
							phase_q     <= PH_LEN;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
					PH_LEN: begin
						phase_q <= (rx_byte == need_len) ? PH_DATA : PH_HUNT;
						cnt_q   <= '0;
					end
					PH_DATA: begin
						if (last) begin
							phase_q      <= PH_HUNT;
							cnt_q        <= '0;
							pkt_s1.reply <= cmd_reply_q;
							pkt_s1.x     <= {payload_q[0], payload_q[1]};
							pkt_s1.y     <= {payload_q[2], payload_q[3]};
							pkt_s1.angle <= {payload_q[4], rx_byte};
							pkt_s1.idx   <= rx_byte;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
					default: phase_q <= PH_HUNT;
				endcase
			end
		end
	end

	// the final byte goes straight into the packet register
	always_ff @(posedge clk) begin
		if (en && rx_valid && (phase_q == PH_DATA) && (cnt_q < LAST_CNT)) begin
			payload_q[cnt_q] <= rx_byte;
		end
	end

endmodule

### hdl/gprpt_sincos.sv
// four-stage sine and cosine of an angle in tenths of a degree, scaled by 10000
module gprpt_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [11:0]        angle,
	output logic signed [14:0] sin_s5,
	output logic signed [14:0] cos_s5
);

	// lane 0 is sine, lane 1 is cosine
	logic [1:0]  quad;
	logic [1:0]  quad_c;
	logic [9:0]  rem;

	logic [9:0]  rs_s2   [0:1];
	logic        neg_s2  [0:1];
	logic [13:0] base_s3 [0:1];
	logic [7:0]  diff_s3 [0:1];
	logic [3:0]  frac_s3 [0:1];
	logic        neg_s3  [0:1];
	logic [13:0] base_s4 [0:1];
	logic [10:0] prod_s4 [0:1];
	logic        neg_s4  [0:1];

	logic [6:0]  k_b     [0:1];
	logic [13:0] val_d   [0:1];
	logic signed [14:0] res_d [0:1];

	function automatic logic [9:0] fold(input logic odd, input logic [9:0] r);
		return odd ? (10'd900 - r) : r;
	endfunction

	function automatic logic [6:0] div10(input logic [9:0] r);
		logic [22:0] p;
		p = 23'(r) * 23'(gprpt_pkg::RECIP10);
		return p[22:16];
	endfunction

	function automatic logic [7:0] idiv10(input logic [10:0] v);
		logic [23:0] p;
		p = 24'(v) * 24'(gprpt_pkg::RECIP10);
		return p[23:16];
	endfunction

	always_comb begin
		if (angle >= 12'd2700) begin
			quad = 2'd3;
			rem  = 10'(angle - 12'd2700);
		end else if (angle >= 12'd1800) begin
			quad = 2'd2;
			rem  = 10'(angle - 12'd1800);
		end else if (angle >= 12'd900) begin
			quad = 2'd1;
			rem  = 10'(angle - 12'd900);
		end else begin
			quad = 2'd0;
			rem  = angle[9:0];
		end
		quad_c = quad + 2'd1;
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			k_b[i]   = div10(rs_s2[i]);
			val_d[i] = base_s4[i] + 14'(idiv10(prod_s4[i]));
			res_d[i] = neg_s4[i] ? -$signed({1'b0, val_d[i]}) : $signed({1'b0, val_d[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s2[0]  <= fold(quad[0], rem);
			neg_s2[0] <= quad[1];
			rs_s2[1]  <= fold(quad_c[0], rem);
			neg_s2[1] <= quad_c[1];
			for (int i = 0; i < 2; i++) begin
				if (k_b[i] >= 7'd90) begin
					base_s3[i] <= gprpt_pkg::TRIG_ONE;
					diff_s3[i] <= '0;
				end else begin
					base_s3[i] <= gprpt_pkg::sin_deg(k_b[i]);
					diff_s3[i] <= 8'(gprpt_pkg::sin_deg(k_b[i] + 7'd1)
						- gprpt_pkg::sin_deg(k_b[i]));
				end
				frac_s3[i] <= 4'(rs_s2[i] - 10'(k_b[i]) * 10'd10);
				neg_s3[i]  <= neg_s2[i];
				base_s4[i] <= base_s3[i];
				prod_s4[i] <= 11'(diff_s3[i]) * 11'(frac_s3[i]);
				neg_s4[i]  <= neg_s3[i];
			end
			sin_s5 <= res_d[0];
			cos_s5 <= res_d[1];
		end
	end

endmodule
